// ===== rtl/udp_latency_probe_defines.svh =====
// assertion macros shared by the latency probe checker
`ifndef UDP_LATENCY_PROBE_DEFINES_SVH
`define UDP_LATENCY_PROBE_DEFINES_SVH

// same-cycle implication, masked during reset
`define ULP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define ULP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define ULP_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ulp_pkg.sv =====
// shared types and constants of the latency probe
package ulp_pkg;

  // roles
  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_CLIENT = 2'd1;
  localparam logic [1:0] ROLE_SERVER = 2'd2;

  // item kinds
  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_RECV = 1'b1;

  // configuration register indexes
  localparam logic REG_MAGIC = 1'b0;
  localparam logic REG_PEER  = 1'b1;

  // minimum header size in bytes
  localparam logic [15:0] HDR_BYTES = 16'd12;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] magic_value;
    logic [31:0] peer_id;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        kind;
    logic [31:0] now_usec;
    logic [15:0] rx_magic;
    logic [15:0] rx_seq;
    logic [31:0] rx_timestamp;
    logic [31:0] rx_ssrc;
    logic [31:0] latency;
    logic        header_ok;
  } item_t;

endpackage

// ===== rtl/udp_latency_probe.sv =====
// Latency probe with an RTP-like 12-byte header.
// Input channel: in_valid / in_stall carry one event per transfer, either a
// send event (kind 0) or a received header (kind 1), each with the current
// microsecond time. Output channel: out_valid / out_stall carry exactly one
// result per input item, in input order: the stamped or echoed header on a
// send, latency, header check and connection id on a receive, and the
// running role and statistics after the item.
// Configuration: wr_en writes wr_data into register wr_index (0 magic word,
// 1 peer id); write only while no item is in flight.
// Path: an accepted item passes the front register, the two-entry queue and
// the result register before out_valid rises and the result can transfer.
// Throughput: one item per cycle while out_stall is low; the back stage does
// the whole state update (64-bit sum and count, 32-bit min and max compares)
// combinationally, ahead of its state registers.
// Reset (rst, synchronous) clears role, sequence number, template,
// statistics and both registers, and empties the pipeline.
// While out_stall is high the result holds; the queue and the front
// register take up to three further items and then in_stall rises.
module udp_latency_probe (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [31:0] now_usec,
  input  logic [15:0] rx_magic,
  input  logic [15:0] rx_seq,
  input  logic [31:0] rx_timestamp,
  input  logic [31:0] rx_ssrc,
  input  logic [15:0] rx_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_magic,
  output logic [15:0] out_seq,
  output logic [31:0] out_timestamp,
  output logic [31:0] out_ssrc,
  output logic [1:0]  role_now,
  output logic [31:0] latency,
  output logic [31:0] min_latency,
  output logic [31:0] max_latency,
  output logic [63:0] total_latency,
  output logic [63:0] packet_count,
  output logic        header_ok,
  output logic [31:0] connection_id
);
  import ulp_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  logic  front_valid;
  logic  front_stall;
  item_t queue_item;
  logic  queue_valid;
  logic  queue_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAGIC: cfg.magic_value <= wr_data[15:0];
        REG_PEER:  cfg.peer_id     <= wr_data;
        default:   cfg             <= cfg;
      endcase
    end
  end

  ulp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .now_usec     (now_usec),
    .rx_magic     (rx_magic),
    .rx_seq       (rx_seq),
    .rx_timestamp (rx_timestamp),
    .rx_ssrc      (rx_ssrc),
    .rx_length    (rx_length),
    .item         (front_item),
    .item_valid   (front_valid),
    .item_stall   (front_stall)
  );

  ulp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .pop_item   (queue_item),
    .pop_valid  (queue_valid),
    .pop_take   (queue_take)
  );

  ulp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item          (queue_item),
    .item_valid    (queue_valid),
    .item_take     (queue_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magic     (out_magic),
    .out_seq       (out_seq),
    .out_timestamp (out_timestamp),
    .out_ssrc      (out_ssrc),
    .role_now      (role_now),
    .latency       (latency),
    .min_latency   (min_latency),
    .max_latency   (max_latency),
    .total_latency (total_latency),
    .packet_count  (packet_count),
    .header_ok     (header_ok),
    .connection_id (connection_id)
  );

endmodule

// ===== rtl/ulp_front.sv =====
// front stage: accepts items, measures latency and checks the header
module ulp_front (
  input  logic           clk,
  input  logic           rst,
  input  ulp_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           kind,
  input  logic [31:0]    now_usec,
  input  logic [15:0]    rx_magic,
  input  logic [15:0]    rx_seq,
  input  logic [31:0]    rx_timestamp,
  input  logic [31:0]    rx_ssrc,
  input  logic [15:0]    rx_length,
  output ulp_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_stall
);
  import ulp_pkg::*;

  logic  valid;
  item_t item_reg;
  item_t classified;
  logic  accept;

  assign in_stall   = valid && item_stall;
  assign accept     = in_valid && !in_stall;
  assign item       = item_reg;
  assign item_valid = valid;

  // classify the incoming item
  always_comb begin
    classified              = '0;
    classified.kind         = kind;
    classified.now_usec     = now_usec;
    classified.rx_magic     = rx_magic;
    classified.rx_seq       = rx_seq;
    classified.rx_timestamp = rx_timestamp;
    classified.rx_ssrc      = rx_ssrc;
    if (kind == KIND_RECV) begin
      classified.latency   = now_usec - rx_timestamp;
      classified.header_ok = (rx_length >= HDR_BYTES) && (rx_magic == cfg.magic_value);
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (!item_stall) begin
      valid <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg <= classified;
    end
  end

endmodule

// ===== rtl/ulp_queue.sv =====
// short queue between the front and back stages
module ulp_queue (
  input  logic           clk,
  input  logic           rst,
  input  ulp_pkg::item_t push_item,
  input  logic           push_valid,
  output logic           push_stall,
  output ulp_pkg::item_t pop_item,
  output logic           pop_valid,
  input  logic           pop_take
);
  import ulp_pkg::*;

  item_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign push_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_take;
  assign pop_item   = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/ulp_back.sv =====
// back stage: role, send template, statistics and the result register
module ulp_back (
  input  logic           clk,
  input  logic           rst,
  input  ulp_pkg::cfg_t  cfg,
  input  ulp_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    out_magic,
  output logic [15:0]    out_seq,
  output logic [31:0]    out_timestamp,
  output logic [31:0]    out_ssrc,
  output logic [1:0]     role_now,
  output logic [31:0]    latency,
  output logic [31:0]    min_latency,
  output logic [31:0]    max_latency,
  output logic [63:0]    total_latency,
  output logic [63:0]    packet_count,
  output logic           header_ok,
  output logic [31:0]    connection_id
);
  import ulp_pkg::*;

  // architectural state
  logic [1:0]  role_state;
  logic [15:0] next_seq;
  logic [15:0] tmpl_magic;
  logic [15:0] tmpl_seq;
  logic [31:0] tmpl_timestamp;
  logic [31:0] tmpl_ssrc;
  logic [31:0] min_store;
  logic [31:0] max_store;
  logic [63:0] total_store;
  logic [63:0] count_store;

  logic [1:0]  role_state_next;
  logic [15:0] next_seq_next;
  logic [15:0] tmpl_magic_next;
  logic [15:0] tmpl_seq_next;
  logic [31:0] tmpl_timestamp_next;
  logic [31:0] tmpl_ssrc_next;
  logic [31:0] min_store_next;
  logic [31:0] max_store_next;
  logic [63:0] total_store_next;
  logic [63:0] count_store_next;

  logic        take;
  logic        is_recv;
  logic [31:0] lat;

  assign item_take = !out_valid || !out_stall;
  assign take      = item_valid && item_take;
  assign is_recv   = (item.kind == KIND_RECV);
  assign lat       = item.latency;

  // next state for one item
  always_comb begin
    role_state_next     = role_state;
    next_seq_next       = next_seq;
    tmpl_magic_next     = tmpl_magic;
    tmpl_seq_next       = tmpl_seq;
    tmpl_timestamp_next = tmpl_timestamp;
    tmpl_ssrc_next      = tmpl_ssrc;
    min_store_next      = min_store;
    max_store_next      = max_store;
    total_store_next    = total_store;
    count_store_next    = count_store;
    if (!is_recv) begin
      if (role_state == ROLE_NONE) begin
        role_state_next = ROLE_CLIENT;
      end
      if (role_state_next == ROLE_CLIENT) begin
        tmpl_magic_next     = cfg.magic_value;
        tmpl_seq_next       = next_seq;
        tmpl_timestamp_next = item.now_usec;
        tmpl_ssrc_next      = cfg.peer_id;
        next_seq_next       = next_seq + 16'd1;
      end
    end else begin
      if (role_state == ROLE_NONE) begin
        role_state_next = ROLE_SERVER;
      end
      count_store_next = count_store + 64'd1;
      total_store_next = total_store + {32'd0, lat};
      if (lat > max_store) begin
        max_store_next = lat;
      end
      if (((lat != '0) && (min_store == '0)) || (lat < min_store)) begin
        min_store_next = lat;
      end
      if (role_state_next == ROLE_SERVER) begin
        tmpl_magic_next     = item.rx_magic;
        tmpl_seq_next       = item.rx_seq;
        tmpl_timestamp_next = item.rx_timestamp;
        tmpl_ssrc_next      = item.rx_ssrc;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      role_state     <= ROLE_NONE;
      next_seq       <= '0;
      tmpl_magic     <= '0;
      tmpl_seq       <= '0;
      tmpl_timestamp <= '0;
      tmpl_ssrc      <= '0;
      min_store      <= '0;
      max_store      <= '0;
      total_store    <= '0;
      count_store    <= '0;
    end else if (take) begin
      role_state     <= role_state_next;
      next_seq       <= next_seq_next;
      tmpl_magic     <= tmpl_magic_next;
      tmpl_seq       <= tmpl_seq_next;
      tmpl_timestamp <= tmpl_timestamp_next;
      tmpl_ssrc      <= tmpl_ssrc_next;
      min_store      <= min_store_next;
      max_store      <= max_store_next;
      total_store    <= total_store_next;
      count_store    <= count_store_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_magic     <= is_recv ? '0 : tmpl_magic_next;
      out_seq       <= is_recv ? '0 : tmpl_seq_next;
      out_timestamp <= is_recv ? '0 : tmpl_timestamp_next;
      out_ssrc      <= is_recv ? '0 : tmpl_ssrc_next;
      role_now      <= role_state_next;
      latency       <= lat;
      min_latency   <= min_store_next;
      max_latency   <= max_store_next;
      total_latency <= total_store_next;
      packet_count  <= count_store_next;
      header_ok     <= item.header_ok;
      connection_id <= item.header_ok ? item.rx_ssrc : '0;
    end
  end

endmodule

// ===== rtl/ulp_checker.sv =====
// port-level checks of the latency probe and their binding
`include "udp_latency_probe_defines.svh"

module ulp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_magic,
  input logic [15:0] out_seq,
  input logic [31:0] out_timestamp,
  input logic [31:0] out_ssrc,
  input logic [1:0]  role_now,
  input logic [31:0] latency,
  input logic        header_ok,
  input logic [31:0] connection_id
);
  import ulp_pkg::*;

  // pipeline is empty right after reset
  `ULP_ASSERT_ALWAYS(a_empty_after_reset, rst, !out_valid, "result valid after reset")

  // a stalled result holds its sequence number and timestamp
  `ULP_ASSERT_NXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_seq) && $stable(out_timestamp), "stalled result changed")

  // every result carries a fixed role
  `ULP_ASSERT_IMP(a_role_set, out_valid, role_now == ROLE_CLIENT || role_now == ROLE_SERVER, "result without role")

  // failed header check gives no connection id
  `ULP_ASSERT_IMP(a_cid_gated, out_valid && !header_ok, connection_id == '0, "connection id without header check")

  // a measured latency comes only with zero magic, sequence and ssrc fields
  `ULP_ASSERT_IMP(a_recv_no_hdr, out_valid && latency != '0, out_magic == '0 && out_seq == '0 && out_ssrc == '0, "receive result carries send header")

endmodule

bind udp_latency_probe ulp_checker u_ulp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_magic     (out_magic),
  .out_seq       (out_seq),
  .out_timestamp (out_timestamp),
  .out_ssrc      (out_ssrc),
  .role_now      (role_now),
  .latency       (latency),
  .header_ok     (header_ok),
  .connection_id (connection_id)
);

// ===== tb/udp_latency_probe_test.sv =====
// self-checking testbench for the udp latency probe: random and directed events, scored results
`timescale 1ns / 100ps

module udp_latency_probe_test;
  import ulp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PRINT_CAP = 40;

  // one input event as offered on the input channel
  typedef struct packed {
    logic        kind;
    logic [31:0] now;
    logic [15:0] magic;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [15:0] length;
  } probe_event_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [15:0] hdr_magic;
    logic [15:0] hdr_seq;
    logic [31:0] hdr_ts;
    logic [31:0] hdr_ssrc;
    logic [1:0]  role;
    logic [31:0] lat;
    logic [31:0] lat_min;
    logic [31:0] lat_max;
    logic [63:0] lat_sum;
    logic [63:0] rx_count;
    logic        hdr_ok;
    logic [31:0] conn_id;
  } probe_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic        wr_index = REG_MAGIC;
  logic [31:0] wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_magic;
  logic [15:0] out_seq;
  logic [31:0] out_timestamp;
  logic [31:0] out_ssrc;
  logic [1:0]  role_now;
  logic [31:0] latency;
  logic [31:0] min_latency;
  logic [31:0] max_latency;
  logic [63:0] total_latency;
  logic [63:0] packet_count;
  logic        header_ok;
  logic [31:0] connection_id;

  probe_event_t offer_ev = '0;
  logic         offer_live = 1'b0;

  probe_event_t  event_backlog[$];
  probe_report_t pending_reports[$];

  // probe state as the scoreboard tracks it
  logic [1:0]  role_st = ROLE_NONE;
  logic [15:0] seq_next = '0;
  logic [15:0] tmpl_magic = '0;
  logic [15:0] tmpl_seq = '0;
  logic [31:0] tmpl_ts = '0;
  logic [31:0] tmpl_ssrc = '0;
  logic [31:0] lat_min = '0;
  logic [31:0] lat_max = '0;
  logic [63:0] lat_sum = '0;
  logic [63:0] rx_count = '0;
  logic [15:0] cfg_magic = '0;
  logic [31:0] cfg_peer = '0;

  logic [31:0] probe_clock;
  int unsigned feed_idle_pct = 0;
  int unsigned drain_idle_pct = 0;
  logic        feed_pause = 1'b0;
  logic        drain_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned sends_in = 0;
  int unsigned headers_in = 0;
  int unsigned headers_ok = 0;
  int unsigned backpressure_cycles = 0;

  udp_latency_probe u_dut (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (offer_ev.kind),
    .now_usec      (offer_ev.now),
    .rx_magic      (offer_ev.magic),
    .rx_seq        (offer_ev.seq),
    .rx_timestamp  (offer_ev.ts),
    .rx_ssrc       (offer_ev.ssrc),
    .rx_length     (offer_ev.length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magic     (out_magic),
    .out_seq       (out_seq),
    .out_timestamp (out_timestamp),
    .out_ssrc      (out_ssrc),
    .role_now      (role_now),
    .latency       (latency),
    .min_latency   (min_latency),
    .max_latency   (max_latency),
    .total_latency (total_latency),
    .packet_count  (packet_count),
    .header_ok     (header_ok),
    .connection_id (connection_id)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // role, template and statistics update for one event
  function automatic probe_report_t predict_probe_report(input probe_event_t ev);
    probe_report_t r;
    logic [31:0]   lat;
    r = '0;
    if (ev.kind == KIND_SEND) begin
      if (role_st == ROLE_NONE) role_st = ROLE_CLIENT;
      if (role_st == ROLE_CLIENT) begin
        tmpl_magic = cfg_magic;
        tmpl_seq = seq_next;
        tmpl_ts = ev.now;
        tmpl_ssrc = cfg_peer;
        seq_next = seq_next + 16'd1;
      end
      r.hdr_magic = tmpl_magic;
      r.hdr_seq = tmpl_seq;
      r.hdr_ts = tmpl_ts;
      r.hdr_ssrc = tmpl_ssrc;
    end else begin
      if (role_st == ROLE_NONE) role_st = ROLE_SERVER;
      lat = ev.now - ev.ts;
      rx_count = rx_count + 64'd1;
      lat_sum = lat_sum + {32'd0, lat};
      if (lat > lat_max) lat_max = lat;
      // a nonzero latency replaces a zero minimum
      if ((lat != 0 && lat_min == 0) || lat < lat_min) lat_min = lat;
      // a server keeps the last header for its echo
      if (role_st == ROLE_SERVER) begin
        tmpl_magic = ev.magic;
        tmpl_seq = ev.seq;
        tmpl_ts = ev.ts;
        tmpl_ssrc = ev.ssrc;
      end
      r.lat = lat;
      if (ev.length >= HDR_BYTES && ev.magic == cfg_magic) begin
        r.hdr_ok = 1'b1;
        r.conn_id = ev.ssrc;
      end
    end
    r.role = role_st;
    r.lat_min = lat_min;
    r.lat_max = lat_max;
    r.lat_sum = lat_sum;
    r.rx_count = rx_count;
    return r;
  endfunction

  function automatic probe_event_t send_event(input logic [31:0] now);
    probe_event_t ev;
    ev.kind = KIND_SEND;
    ev.now = now;
    ev.magic = 16'($urandom);
    ev.seq = 16'($urandom);
    ev.ts = $urandom;
    ev.ssrc = $urandom;
    ev.length = 16'($urandom);
    return ev;
  endfunction

  function automatic probe_event_t header_event(input logic [31:0] now, input logic [31:0] ts,
                                                input logic [15:0] magic, input logic [15:0] seq,
                                                input logic [31:0] ssrc, input logic [15:0] len);
    probe_event_t ev;
    ev.kind = KIND_RECV;
    ev.now = now;
    ev.ts = ts;
    ev.magic = magic;
    ev.seq = seq;
    ev.ssrc = ssrc;
    ev.length = len;
    return ev;
  endfunction

  // mostly well-formed traffic, some broken headers, some pure noise
  function automatic probe_event_t random_event();
    probe_event_t ev;
    int unsigned  pick;
    logic [15:0]  flip;
    pick = $urandom_range(99);
    probe_clock = probe_clock + $urandom_range(400);
    ev = send_event(probe_clock);
    ev.kind = 1'($urandom_range(1));
    if (pick < 85) begin
      ev.kind = (pick < 42) ? KIND_SEND : KIND_RECV;
      ev.magic = cfg_magic;
      ev.length = (pick % 4 == 0) ? 16'($urandom_range(65535, 12)) : 16'($urandom_range(40, 12));
      case ($urandom_range(9))
        0: ev.ts = ev.now;
        1: ev.ts = $urandom;
        default: ev.ts = ev.now - $urandom_range(2000, 1);
      endcase
    end else if (pick < 93) begin
      // short or foreign header
      ev.kind = KIND_RECV;
      ev.ts = ev.now - $urandom_range(2000);
      ev.magic = cfg_magic;
      flip = 16'($urandom_range(65535, 1));
      if ($urandom_range(1)) ev.length = 16'($urandom_range(11));
      else ev.magic = cfg_magic ^ flip;
    end else begin
      ev.now = $urandom;
    end
    return ev;
  endfunction

  task automatic queue_random(input int unsigned n);
    repeat (n) event_backlog.push_back(random_event());
  endtask

  task automatic queue_directed();
    logic [15:0] m;
    m = cfg_magic;
    // the first event decides the role for the whole run
    if ($urandom_range(1)) event_backlog.push_back(header_event(32'h0000_1234, 32'h0000_1234,
                                                                m, 16'h0001, 32'h0BAD_F00D, 16'd12));
    else event_backlog.push_back(send_event(32'd0));
    event_backlog.push_back(send_event(32'hFFFF_FFFF));
    event_backlog.push_back(send_event(32'd0));
    event_backlog.push_back(header_event(32'h0000_5000, 32'h0000_5000, m, 16'h0002,
                                         32'h1111_2222, 16'd12));
    event_backlog.push_back(header_event(32'h0000_6000, 32'h0000_6000 - 32'd100, m, 16'h0003,
                                         32'h2222_3333, 16'd20));
    event_backlog.push_back(header_event(32'h0000_7000, 32'h0000_7000 - 32'd5, m, 16'h0004,
                                         32'h3333_4444, 16'd12));
    event_backlog.push_back(header_event(32'h0000_9000, 32'h0000_9000 - 32'd5000, m, 16'h0005,
                                         32'h4444_5555, 16'd12));
    // timestamp ahead of now: latency wraps to its largest value
    event_backlog.push_back(header_event(32'd0, 32'd1, m, 16'h0006, 32'h5555_6666, 16'd12));
    event_backlog.push_back(header_event(32'h0001_0000, 32'h0000_FF00, m, 16'h0007,
                                         32'h6666_7777, 16'd11));
    event_backlog.push_back(header_event(32'h0002_0000, 32'h0001_FFF0, m, 16'h0008,
                                         32'hFFFF_FFFF, 16'hFFFF));
    event_backlog.push_back(header_event(32'h0003_0000, 32'h0002_FFF0, ~m, 16'h0009,
                                         32'h7777_8888, 16'd0));
    event_backlog.push_back(header_event(32'h0004_0000, 32'h0003_FFF0, ~m, 16'h000A,
                                         32'h8888_9999, 16'd12));
    event_backlog.push_back(header_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                         32'hFFFF_FFFF, 16'hFFFF));
    event_backlog.push_back(send_event(32'h0005_0000));
    event_backlog.push_back(header_event(32'd0, 32'd0, 16'h0000, 16'h0000, 32'd0, 16'd0));
    event_backlog.push_back(send_event(32'h0006_0000));
    event_backlog.push_back(send_event(32'h0007_0000));
  endtask

  // register write, only called with nothing in flight
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_MAGIC) cfg_magic = value[15:0];
    else cfg_peer = value;
  endtask

  task automatic write_magic(input logic [15:0] magic);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_MAGIC, {junk, magic});
  endtask

  task automatic wait_idle();
    while (event_backlog.size() != 0 || offer_live || pending_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_error(input string msg);
    if (error_count < PRINT_CAP) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h, expected %0h", results_seen, name, got,
                             want));
  endtask

  // input driver: hold the offer until its transfer, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!offer_live) begin
      if (event_backlog.size() != 0 && !feed_pause && $urandom_range(99) >= feed_idle_pct) begin
        offer_ev <= event_backlog.pop_front();
        offer_live = 1'b1;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input transfer: predict the result of the accepted event
  always @(posedge clk) begin
    if (!rst && in_valid) begin
      if (in_stall) begin
        backpressure_cycles++;
      end else begin
        pending_reports.push_back(predict_probe_report(offer_ev));
        if (offer_ev.kind == KIND_SEND) sends_in++;
        else headers_in++;
        if (pending_reports[$].hdr_ok) headers_ok++;
        offer_live = 1'b0;
      end
    end
  end

  // receiver stall: random, or one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (drain_hold_req) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      drain_hold_req = 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < drain_idle_pct);
    end
  end

  // output monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_monitor
    probe_report_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_reports.pop_front();
        compare_field("out_magic", 64'(out_magic), 64'(want.hdr_magic));
        compare_field("out_seq", 64'(out_seq), 64'(want.hdr_seq));
        compare_field("out_timestamp", 64'(out_timestamp), 64'(want.hdr_ts));
        compare_field("out_ssrc", 64'(out_ssrc), 64'(want.hdr_ssrc));
        compare_field("role_now", 64'(role_now), 64'(want.role));
        compare_field("latency", 64'(latency), 64'(want.lat));
        compare_field("min_latency", 64'(min_latency), 64'(want.lat_min));
        compare_field("max_latency", 64'(max_latency), 64'(want.lat_max));
        compare_field("total_latency", total_latency, want.lat_sum);
        compare_field("packet_count", packet_count, want.rx_count);
        compare_field("header_ok", 64'(header_ok), 64'(want.hdr_ok));
        compare_field("connection_id", 64'(connection_id), 64'(want.conn_id));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
               pending_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    probe_clock = $urandom;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed events with magic at zero and an all-ones peer id
    write_magic(16'h0000);
    write_reg(REG_PEER, 32'hFFFF_FFFF);
    feed_idle_pct = 7;
    drain_idle_pct = 72;
    queue_directed();
    wait_idle();

    // sender mostly busy, receiver mostly stalled
    write_magic(16'hFFFF);
    write_reg(REG_PEER, 32'h0000_0000);
    feed_idle_pct = 7;
    drain_idle_pct = 72;
    queue_random(400);
    wait_idle();

    // sender mostly idle, with one pause until every result is back
    write_magic(16'($urandom));
    write_reg(REG_PEER, $urandom);
    feed_idle_pct = 72;
    drain_idle_pct = 7;
    queue_random(200);
    while (event_backlog.size() > 100) @(negedge clk);
    feed_pause = 1'b1;
    while (offer_live || pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    feed_pause = 1'b0;
    queue_random(200);
    wait_idle();

    // no idling, one long receiver hold-off so the input backs up
    write_magic(16'($urandom));
    write_reg(REG_PEER, $urandom);
    feed_idle_pct = 0;
    drain_idle_pct = 0;
    queue_random(400);
    drain_hold_req = 1'b1;
    wait_idle();

    $display("run as %s: %0d sends, %0d headers (%0d passing the check), %0d results checked",
             (role_st == ROLE_CLIENT) ? "client" : "server", sends_in, headers_in, headers_ok,
             results_seen);
    $display("input held off for %0d cycles, %0d mismatches", backpressure_cycles,
             error_count);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== udp_latency_probe.f =====
+incdir+rtl
rtl/ulp_pkg.sv
rtl/ulp_front.sv
rtl/ulp_queue.sv
rtl/ulp_back.sv
rtl/udp_latency_probe.sv
rtl/ulp_checker.sv
tb/udp_latency_probe_test.sv
